@@ hw/rtl/bfwe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfwe_pkg: shared types and constants for the word enumerator
// Request and result payloads, controller command and datapath status
// structs, state encoding and character set constants.
// ----------------------------------------------------------------------------
package bfwe_pkg;

  localparam int DEF_MAX_LENGTH = 16;
  localparam int DEF_MAX_CUSTOM = 64;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;
  localparam int WLEN_W      = 5;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_WORD_LENGTH   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHAR_SET_MODE = 4'd1;

  // Request operations.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  // Character set modes.
  localparam logic [1:0] MODE_ALNUM        = 2'd0;
  localparam logic [1:0] MODE_LOWER_DIGITS = 2'd1;
  localparam logic [1:0] MODE_DIGITS       = 2'd2;
  localparam logic [1:0] MODE_CUSTOM       = 2'd3;

  // Add status codes.
  localparam logic [1:0] ADD_OK   = 2'd0;
  localparam logic [1:0] ADD_DUP  = 2'd1;
  localparam logic [1:0] ADD_FULL = 2'd2;

  localparam int SET_SIZE_ALNUM        = 62;
  localparam int SET_SIZE_LOWER_DIGITS = 36;
  localparam int SET_SIZE_DIGITS       = 10;

  localparam logic [7:0] CHR_UPPER_A = 8'd65;
  localparam logic [7:0] CHR_LOWER_A = 8'd97;
  localparam logic [7:0] CHR_ZERO    = 8'd48;
  localparam logic [5:0] LETTERS     = 6'd26;

  typedef struct packed {
    logic       op;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
    logic       exhausted;
    logic [1:0] add_status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_NX_CHECK,
    ST_NX_EMIT,
    ST_ADV_RD,
    ST_ADV_WR
  } state_t;

  typedef struct packed {
    logic       latch;
    logic       clr_idx;
    logic       idx_last;
    logic       idx_dec;
    logic       scan;
    logic       scan_cust;
    logic       emit;
    logic       dig_wr;
    logic       add_write;
    logic       res_add;
    logic [1:0] add_code;
    logic       res_exh;
    logic       set_fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic finished;
    logic set_empty;
    logic scan_more;
    logic pend1;
    logic hit;
    logic bad;
    logic cust_full;
    logic emit_done;
    logic carry;
    logic idx_zero;
  } dp_stat_t;

  // Character of a built-in set for a digit value below the set size.
  function automatic logic [7:0] builtin_char(input logic [1:0] mode, input logic [5:0] idx);
    logic [7:0] ch;
    ch = '0;
    case (mode)
      MODE_ALNUM: begin
        if (idx < LETTERS) ch = CHR_UPPER_A + {2'b00, idx};
        else if (idx < 6'(2 * 26)) ch = CHR_LOWER_A + {2'b00, idx - LETTERS};
        else ch = CHR_ZERO + {2'b00, idx - 6'(2 * 26)};
      end
      MODE_LOWER_DIGITS: begin
        if (idx < LETTERS) ch = CHR_LOWER_A + {2'b00, idx};
        else ch = CHR_ZERO + {2'b00, idx - LETTERS};
      end
      MODE_DIGITS: ch = CHR_ZERO + {2'b00, idx};
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bfwe_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfwe_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bfwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/bfwe_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfwe_dp: enumerator datapath
// Configuration registers, digit and custom character memories, scan
// counter, two-stage character read pipeline and the result register.
// ----------------------------------------------------------------------------
module bfwe_dp #(
  parameter int MAX_LENGTH = 16,
  parameter int MAX_CUSTOM = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bfwe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bfwe_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [7:0]                          char_in,
  input  bfwe_pkg::ctl_cmd_t                  cmd,
  output bfwe_pkg::dp_stat_t                  stat,
  output logic                                result_valid,
  output bfwe_pkg::out_item_t                 result
);
  import bfwe_pkg::*;

  localparam int LEN_W   = $clog2(MAX_LENGTH + 1);
  localparam int DIG_AW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CNT_W   = $clog2(MAX_CUSTOM + 1);
  localparam int CUST_AW = (MAX_CUSTOM > 1) ? $clog2(MAX_CUSTOM) : 1;
  localparam int MAX_SET = (MAX_CUSTOM > SET_SIZE_ALNUM) ? MAX_CUSTOM : SET_SIZE_ALNUM;
  localparam int SZ_W    = $clog2(MAX_SET + 1);
  localparam int IDX_W   = (LEN_W > CNT_W) ? LEN_W : CNT_W;

  logic [WLEN_W-1:0]     word_length;
  logic [1:0]            char_set_mode;
  logic [CNT_W-1:0]      custom_count;
  logic                  finished;
  logic [7:0]            char_q;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W:0]        idx_inc;
  logic [IDX_W-1:0]      lim;
  logic                  issue;
  logic                  pend1;
  logic                  last1;
  logic                  pend2;
  logic                  last2;
  logic [7:0]            char2;
  logic [LEN_W-1:0]      len;
  logic [SZ_W-1:0]       set_n;
  logic [MAX_LENGTH-1:0] dig_valid;
  logic                  dig_vq;
  logic [SZ_W-1:0]       dig_rdata;
  logic [SZ_W-1:0]       digit;
  logic [SZ_W-1:0]       digit_inc;
  logic [7:0]            cust_rdata;
  logic [CUST_AW-1:0]    cust_rd_addr;
  logic [7:0]            emit_char;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_length   <= WLEN_W'(1);
      char_set_mode <= MODE_ALNUM;
    end else if (cfg_we) begin
      if (cfg_index == REG_WORD_LENGTH) word_length <= cfg_data[WLEN_W-1:0];
      else if (cfg_index == REG_CHAR_SET_MODE) char_set_mode <= cfg_data[1:0];
    end
  end

  always_comb begin
    if (word_length == '0) len = LEN_W'(1);
    else if (int'(word_length) > MAX_LENGTH) len = LEN_W'(MAX_LENGTH);
    else len = LEN_W'(word_length);
  end

  always_comb begin
    unique case (char_set_mode)
      MODE_ALNUM:        set_n = SZ_W'(SET_SIZE_ALNUM);
      MODE_LOWER_DIGITS: set_n = SZ_W'(SET_SIZE_LOWER_DIGITS);
      MODE_DIGITS:       set_n = SZ_W'(SET_SIZE_DIGITS);
      MODE_CUSTOM:       set_n = SZ_W'(custom_count);
    endcase
  end

  // Scan counter, shared by the duplicate search, digit check and emission.
  assign lim     = cmd.scan_cust ? IDX_W'(custom_count) : IDX_W'(len);
  assign issue   = cmd.scan && (idx < lim);
  assign idx_inc = {1'b0, idx} + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.clr_idx) idx <= '0;
    else if (cmd.idx_last) idx <= IDX_W'(len) - 1'b1;
    else if (cmd.idx_dec) idx <= idx - 1'b1;
    else if (issue) idx <= idx_inc[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend1 <= 1'b0;
      pend2 <= 1'b0;
    end else begin
      pend1 <= issue;
      pend2 <= pend1 && cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) char_q <= char_in;
    last1 <= idx_inc == {1'b0, lim};
    last2 <= last1;
    char2 <= builtin_char(char_set_mode, digit[5:0]);
  end

  // Digit store: entries read as zero until first written after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      dig_valid <= '0;
    end else if (cmd.dig_wr) begin
      dig_valid[idx[DIG_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    dig_vq <= dig_valid[idx[DIG_AW-1:0]];
  end

  assign digit     = dig_vq ? dig_rdata : '0;
  assign digit_inc = digit + 1'b1;

  bfwe_ram #(
    .WIDTH (SZ_W),
    .DEPTH (MAX_LENGTH),
    .AW    (DIG_AW)
  ) u_dig_ram (
    .clk     (clk),
    .wr_en   (cmd.dig_wr),
    .wr_addr (idx[DIG_AW-1:0]),
    .wr_data ((digit_inc >= set_n) ? '0 : digit_inc),
    .rd_addr (idx[DIG_AW-1:0]),
    .rd_data (dig_rdata)
  );

  // Custom set: the address is the scan index while searching for a
  // duplicate, and the digit value while emitting characters.
  assign cust_rd_addr = cmd.scan_cust ? idx[CUST_AW-1:0] : digit[CUST_AW-1:0];

  bfwe_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CUSTOM),
    .AW    (CUST_AW)
  ) u_cust_ram (
    .clk     (clk),
    .wr_en   (cmd.add_write),
    .wr_addr (custom_count[CUST_AW-1:0]),
    .wr_data (char_q),
    .rd_addr (cust_rd_addr),
    .rd_data (cust_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      custom_count <= '0;
      finished     <= 1'b0;
    end else begin
      if (cmd.add_write) custom_count <= custom_count + 1'b1;
      if (cmd.set_fin) finished <= 1'b1;
    end
  end

  assign emit_char = (char_set_mode == MODE_CUSTOM) ? cust_rdata : char2;

  always_comb begin
    stat           = '0;
    stat.finished  = finished;
    stat.set_empty = set_n == '0;
    stat.scan_more = idx < lim;
    stat.pend1     = pend1;
    stat.hit       = pend1 && (cust_rdata == char_q);
    stat.bad       = pend1 && (digit >= set_n);
    stat.cust_full = custom_count >= CNT_W'(MAX_CUSTOM);
    stat.emit_done = pend2 && last2;
    stat.carry     = digit_inc >= set_n;
    stat.idx_zero  = idx == '0;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= cmd.res_add || cmd.res_exh || pend2;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_add) begin
      result <= '{char_out: 8'd0, last: 1'b1, exhausted: 1'b0, add_status: cmd.add_code};
    end else if (cmd.res_exh) begin
      result <= '{char_out: 8'd0, last: 1'b1, exhausted: 1'b1, add_status: ADD_OK};
    end else if (pend2) begin
      result <= '{char_out: emit_char, last: last2, exhausted: 1'b0, add_status: ADD_OK};
    end
  end

  a_exh_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.exhausted) |-> (result.last && result.char_out == 8'd0))
    else $error("exhausted result without last flag or with a character");

  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    pend2 |-> $past(pend1))
    else $error("character stage valid without a digit read before it");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    custom_count <= CNT_W'(MAX_CUSTOM))
    else $error("custom character count beyond table size");

endmodule
`default_nettype wire

@@ hw/rtl/bfwe_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfwe_ctrl: enumerator controller
// Sequences the duplicate search for adds, and the digit check, character
// emission and odometer advance for next requests.
// ----------------------------------------------------------------------------
module bfwe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               op,
  input  bfwe_pkg::dp_stat_t stat,
  output bfwe_pkg::ctl_cmd_t cmd,
  output logic               busy
);
  import bfwe_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign busy = state != ST_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.latch   = 1'b1;
          cmd.clr_idx = 1'b1;
          if (op == OP_ADD) begin
            state_next = ST_ADD_SCAN;
          end else if (stat.finished || stat.set_empty) begin
            cmd.res_exh = 1'b1;
          end else begin
            state_next = ST_NX_CHECK;
          end
        end
      end
      ST_ADD_SCAN: begin
        cmd.scan      = 1'b1;
        cmd.scan_cust = 1'b1;
        if (stat.hit) begin
          cmd.res_add  = 1'b1;
          cmd.add_code = ADD_DUP;
          state_next   = ST_IDLE;
        end else if (!stat.scan_more && !stat.pend1) begin
          cmd.res_add = 1'b1;
          if (stat.cust_full) begin
            cmd.add_code = ADD_FULL;
          end else begin
            cmd.add_code  = ADD_OK;
            cmd.add_write = 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
      ST_NX_CHECK: begin
        cmd.scan = 1'b1;
        if (stat.bad) begin
          cmd.res_exh = 1'b1;
          cmd.set_fin = 1'b1;
          state_next  = ST_IDLE;
        end else if (!stat.scan_more && !stat.pend1) begin
          cmd.clr_idx = 1'b1;
          state_next  = ST_NX_EMIT;
        end
      end
      ST_NX_EMIT: begin
        cmd.scan = 1'b1;
        cmd.emit = 1'b1;
        if (stat.emit_done) begin
          cmd.idx_last = 1'b1;
          state_next   = ST_ADV_RD;
        end
      end
      ST_ADV_RD: begin
        state_next = ST_ADV_WR;
      end
      ST_ADV_WR: begin
        // A carry out of the most significant position ends the count.
        if (!stat.carry) begin
          cmd.dig_wr = 1'b1;
          state_next = ST_IDLE;
        end else if (stat.idx_zero) begin
          cmd.set_fin = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          cmd.dig_wr  = 1'b1;
          cmd.idx_dec = 1'b1;
          state_next  = ST_ADV_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_adv_pairs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADV_WR) |-> ($past(state) == ST_ADV_RD))
    else $error("advance write step without a read step before it");

  a_add_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_ADD) |=> (state == ST_ADD_SCAN))
    else $error("add request did not start the duplicate search");

  a_no_exh_in_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NX_EMIT) |-> !(cmd.res_exh || cmd.res_add))
    else $error("status result issued while emitting a word");

endmodule
`default_nettype wire

@@ hw/rtl/brute_force_word_enumerator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// brute_force_word_enumerator_top: word enumerator over a character set
// Results cannot be held off.
// Add request: one status result after a duplicate search of the custom table,
//   one table read per cycle.
// Next request: L characters (L = length) in consecutive cycles, or a single
//   exhausted result.
// Synchronous reset clears the digits, the custom count and the finished flag.
// ----------------------------------------------------------------------------
module brute_force_word_enumerator_top #(
  parameter int MAX_LENGTH = bfwe_pkg::DEF_MAX_LENGTH,
  parameter int MAX_CUSTOM = bfwe_pkg::DEF_MAX_CUSTOM
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  bfwe_pkg::in_item_t               req,
  output logic                             result_valid,
  output bfwe_pkg::out_item_t              result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfwe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfwe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bfwe_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bfwe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (req.op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bfwe_dp #(
    .MAX_LENGTH (MAX_LENGTH),
    .MAX_CUSTOM (MAX_CUSTOM)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .char_in      (req.char_in),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire

@@ verif/word_enum_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_enum_checker: scoreboard for the word enumerator
// Watches the request, result and register channels, keeps its own odometer,
// custom table and settings, predicts the results of every accepted request
// and compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module word_enum_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  bfwe_pkg::in_item_t               req,
  input  logic                             result_valid,
  input  bfwe_pkg::out_item_t              result,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [bfwe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfwe_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               errors,
  output int                               pending,
  output logic [6:0]                       lead_digit,
  output logic [6:0]                       digit_peak,
  output int                               table_fill
);
  import bfwe_pkg::*;

  localparam int LEN_CAP   = DEF_MAX_LENGTH;
  localparam int TABLE_CAP = DEF_MAX_CUSTOM;

  logic [6:0] odometer [LEN_CAP];
  logic [7:0] charset [TABLE_CAP];
  int         charset_fill;
  bit         odo_done;
  logic [4:0] cfg_length;
  logic [1:0] cfg_mode;
  out_item_t  awaited_outputs [$];
  int         fails;

  assign errors = fails;

  function automatic int set_size();
    case (cfg_mode)
      MODE_ALNUM:        return SET_SIZE_ALNUM;
      MODE_LOWER_DIGITS: return SET_SIZE_LOWER_DIGITS;
      MODE_DIGITS:       return SET_SIZE_DIGITS;
      default:           return charset_fill;
    endcase
  endfunction

  function automatic logic [7:0] symbol(int idx);
    int letters;
    letters = int'(LETTERS);
    case (cfg_mode)
      MODE_ALNUM: begin
        if (idx < letters) return CHR_UPPER_A + 8'(idx);
        if (idx < 2 * letters) return CHR_LOWER_A + 8'(idx - letters);
        return CHR_ZERO + 8'(idx - 2 * letters);
      end
      MODE_LOWER_DIGITS: begin
        if (idx < letters) return CHR_LOWER_A + 8'(idx);
        return CHR_ZERO + 8'(idx - letters);
      end
      MODE_DIGITS: return CHR_ZERO + 8'(idx);
      default: return charset[idx];
    endcase
  endfunction

  function automatic out_item_t make_out(logic [7:0] ch, logic lst, logic exh,
                                         logic [1:0] code);
    out_item_t o;
    o.char_out   = ch;
    o.last       = lst;
    o.exhausted  = exh;
    o.add_status = code;
    return o;
  endfunction

  function automatic void queue_result(out_item_t o);
    awaited_outputs.insert(awaited_outputs.size(), o);
  endfunction

  // The duplicate check comes first, so a known character reports a duplicate
  // even when the table is full.
  task automatic add_custom_char(logic [7:0] ch);
    logic [1:0] code;
    code = ADD_OK;
    for (int i = 0; i < charset_fill; i++)
      if (charset[i] == ch) code = ADD_DUP;
    if (code == ADD_OK && charset_fill >= TABLE_CAP) code = ADD_FULL;
    if (code == ADD_OK) begin
      charset[charset_fill] = ch;
      charset_fill++;
    end
    queue_result(make_out('0, 1'b1, 1'b0, code));
  endtask

  task automatic enumerate_next();
    int n;
    int len;
    int pos;
    bit stray;
    bit carry;
    n = set_size();
    if (cfg_length == 0) len = 1;
    else if (cfg_length > LEN_CAP) len = LEN_CAP;
    else len = int'(cfg_length);
    stray = 1'b0;
    for (int i = 0; i < len; i++)
      if (odometer[i] >= n) stray = 1'b1;
    if (odo_done || n == 0) begin
      queue_result(make_out('0, 1'b1, 1'b1, ADD_OK));
    end else if (stray) begin
      // A digit left over from a larger set ends the count for good.
      odo_done = 1'b1;
      queue_result(make_out('0, 1'b1, 1'b1, ADD_OK));
    end else begin
      for (int i = 0; i < len; i++)
        queue_result(make_out(symbol(odometer[i]), i == len - 1, 1'b0, ADD_OK));
      pos = len - 1;
      carry = 1'b1;
      while (carry) begin
        odometer[pos] = odometer[pos] + 7'd1;
        if (odometer[pos] < n) begin
          carry = 1'b0;
        end else if (pos == 0) begin
          odo_done = 1'b1;
          carry = 1'b0;
        end else begin
          odometer[pos] = '0;
          pos--;
        end
      end
    end
  endtask

  task automatic compare_result(out_item_t want);
    if (result.char_out !== want.char_out) begin
      $error("char_out: expected %0h, got %0h", want.char_out, result.char_out);
      fails++;
    end
    if (result.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, result.last);
      fails++;
    end
    if (result.exhausted !== want.exhausted) begin
      $error("exhausted: expected %0b, got %0b", want.exhausted, result.exhausted);
      fails++;
    end
    if (result.add_status !== want.add_status) begin
      $error("add_status: expected %0d, got %0d", want.add_status, result.add_status);
      fails++;
    end
  endtask

  always @(posedge clk) begin : observe
    logic [6:0] peak;
    if (rst) begin
      for (int i = 0; i < LEN_CAP; i++) odometer[i] = '0;
      charset_fill = 0;
      odo_done     = 1'b0;
      cfg_length   = 5'd1;
      cfg_mode     = MODE_ALNUM;
      fails        = 0;
      awaited_outputs.delete();
    end else begin
      if (result_valid) begin
        if (awaited_outputs.size() == 0) begin
          $error("unexpected result: char_out %0h last %0b exhausted %0b add_status %0d",
                 result.char_out, result.last, result.exhausted, result.add_status);
          fails++;
        end else begin
          compare_result(awaited_outputs.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WORD_LENGTH) cfg_length = cfg_data[WLEN_W-1:0];
        else if (cfg_index == REG_CHAR_SET_MODE) cfg_mode = cfg_data[1:0];
      end
      if (start && !busy) begin
        if (req.op == OP_ADD) add_custom_char(req.char_in);
        else enumerate_next();
      end
    end
    peak = '0;
    for (int i = 0; i < LEN_CAP; i++)
      if (odometer[i] > peak) peak = odometer[i];
    pending    <= awaited_outputs.size();
    lead_digit <= odometer[0];
    digit_peak <= peak;
    table_fill <= charset_fill;
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the brute-force word enumerator
// Drives a directed opening (empty set, custom adds with duplicates, length
// clamping, every character set), then fills the custom table and runs
// random settings and requests with random idle gaps, and ends the count
// either by running past the final word or by a digit outside a smaller set.
// ----------------------------------------------------------------------------
module tb;
  import bfwe_pkg::*;

  localparam int IDLE_PERCENT = 25;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 185;
  localparam int TABLE_CAP    = DEF_MAX_CUSTOM;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'hF;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  in_item_t               req;
  logic                   result_valid;
  out_item_t              result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     errors;
  int                     pending;
  int                     table_fill;
  logic [6:0]             lead_digit;
  logic [6:0]             digit_peak;
  int                     stall_cycles;
  int                     random_items;
  bit                     steady;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  brute_force_word_enumerator_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  word_enum_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .lead_digit   (lead_digit),
    .digit_peak   (digit_peak),
    .table_fill   (table_fill)
  );

  // Every task below is entered and left at a falling edge.
  task automatic hold_off();
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start = 1'b0;
      cfg_valid = 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic send_request(logic op, logic [7:0] ch);
    hold_off();
    start = 1'b1;
    req.op = op;
    req.char_in = ch;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_next();
    send_request(OP_NEXT, 8'($urandom));
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    hold_off();
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Chooses a setting that cannot end the count early: every stored digit
  // stays inside the new set, and short words cannot roll the leading digit
  // past the end of the set within one batch.
  task automatic pick_setting(int batch);
    int roll;
    int len;
    int size;
    logic [1:0] mode;
    roll = $urandom_range(0, 9);
    if (roll < 6) len = $urandom_range(3, DEF_MAX_LENGTH);
    else if (roll < 8) len = $urandom_range(DEF_MAX_LENGTH + 1, 31);
    else len = $urandom_range(0, 2);
    mode = 2'($urandom_range(0, 3));
    case (mode)
      MODE_ALNUM:        size = SET_SIZE_ALNUM;
      MODE_LOWER_DIGITS: size = SET_SIZE_LOWER_DIGITS;
      MODE_DIGITS:       size = SET_SIZE_DIGITS;
      default:           size = table_fill;
    endcase
    if (size <= digit_peak || lead_digit + 2 >= size) begin
      mode = MODE_CUSTOM;
      size = table_fill;
    end
    if (len <= 2 && lead_digit + batch >= size) len = $urandom_range(3, DEF_MAX_LENGTH);
    write_reg(REG_WORD_LENGTH, {3'($urandom), 5'(len)});
    write_reg(REG_CHAR_SET_MODE, {6'($urandom), mode});
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int batch;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 1'b0;
    random_items = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty custom set with a zero length.
    write_reg(REG_CHAR_SET_MODE, {6'd0, MODE_CUSTOM});
    write_reg(REG_WORD_LENGTH, 8'd0);
    write_reg(REG_UNUSED, 8'hFF);
    send_next();

    // Custom characters with a duplicate, every bit of the byte both ways.
    send_request(OP_ADD, 8'h00);
    send_request(OP_ADD, 8'hFF);
    send_request(OP_ADD, 8'h00);
    send_request(OP_ADD, 8'h80);
    send_request(OP_ADD, 8'h7F);
    send_request(OP_ADD, 8'h01);
    send_request(OP_ADD, 8'hFE);
    send_next();
    send_next();

    write_reg(REG_WORD_LENGTH, 8'd16);
    send_next();
    send_next();

    // Length above the maximum is clamped.
    write_reg(REG_CHAR_SET_MODE, {6'h3F, MODE_ALNUM});
    write_reg(REG_WORD_LENGTH, 8'hFF);
    send_next();
    write_reg(REG_WORD_LENGTH, 8'd5);
    write_reg(REG_CHAR_SET_MODE, {6'd0, MODE_LOWER_DIGITS});
    send_next();
    write_reg(REG_CHAR_SET_MODE, {6'd0, MODE_DIGITS});
    send_next();

    // Fill the custom table, with some words counted in between.
    while (table_fill < TABLE_CAP) begin
      if ($urandom_range(0, 3) == 0) send_next();
      else send_request(OP_ADD, 8'($urandom));
      random_items++;
    end

    // Random settings, each followed by a batch of requests.
    while (random_items < RANDOM_ITEMS) begin
      batch = $urandom_range(4, 16);
      pick_setting(batch);
      for (int k = 0; k < batch; k++) begin
        steady = (random_items >= 120 && random_items < 160);
        if ($urandom_range(0, 4) == 0) send_request(OP_ADD, 8'($urandom));
        else send_next();
        random_items++;
      end
    end
    steady = 1'b0;

    if ($urandom_range(0, 1) == 1) begin
      // Run past the final word of a one-character custom count.
      write_reg(REG_WORD_LENGTH, 8'd1);
      write_reg(REG_CHAR_SET_MODE, {6'd0, MODE_CUSTOM});
      for (int k = 0; k < TABLE_CAP + 2 && lead_digit < 7'(TABLE_CAP); k++) send_next();
    end else begin
      // Leave a digit of ten or more, then shrink the set to digits only.
      write_reg(REG_WORD_LENGTH, 8'd1);
      write_reg(REG_CHAR_SET_MODE, {6'd0, MODE_ALNUM});
      for (int k = 0; k < SET_SIZE_DIGITS + 1 && lead_digit < 7'(SET_SIZE_DIGITS); k++)
        send_next();
      write_reg(REG_CHAR_SET_MODE, {6'd0, MODE_DIGITS});
      send_next();
    end
    // Once the count has ended, every word request stays exhausted.
    send_next();
    send_next();
    send_request(OP_ADD, 8'($urandom));
    send_next();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
